>>> hw/rtl/htlit_pkg.sv
// ----------------------------------------------------------------------------
// htlit_pkg
// Shared types and constants of the timer, LCD mode and interrupt tick unit.
// ----------------------------------------------------------------------------
package htlit_pkg;

	localparam int unsigned TICKS_PER_FRAME_DEF = 70224;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_IRQ_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_RUN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_RATE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_RELOAD = 2'd3;

	// timer rate select codes
	localparam logic [1:0] RATE_1024 = 2'd0;
	localparam logic [1:0] RATE_16   = 2'd1;
	localparam logic [1:0] RATE_64   = 2'd2;
	localparam logic [1:0] RATE_256  = 2'd3;

	// interrupt sources
	localparam int unsigned IRQ_N = 5;
	localparam int unsigned IRQ_VBLANK = 0;
	localparam int unsigned IRQ_STAT   = 1;
	localparam int unsigned IRQ_TIMER  = 2;
	localparam logic [6:0] IRQ_VEC_BASE = 7'h40;

	// LCD sequencer
	localparam logic [8:0] DOTS_OAM    = 9'd80;
	localparam logic [8:0] DOTS_XFER   = 9'd172;
	localparam logic [8:0] DOTS_HBLANK = 9'd204;
	localparam logic [8:0] DOTS_LINE   = 9'd456;
	localparam logic [7:0] LAST_VISIBLE_LINE = 8'd143;
	localparam logic [7:0] LAST_LINE = 8'd153;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} lcd_mode_t;

	typedef struct packed {
		logic stat;
		logic vblank;
		logic render;
	} lcd_evt_t;

endpackage

>>> hw/rtl/htlit_lcd_seq.sv
// ----------------------------------------------------------------------------
// htlit_lcd_seq
// LCD mode sequencer: dot wait counter, mode register and scanline counter.
// ----------------------------------------------------------------------------
module htlit_lcd_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	output htlit_pkg::lcd_mode_t  mode_nxt,
	output logic [7:0]            line_nxt,
	output htlit_pkg::lcd_evt_t   evt
);
	import htlit_pkg::*;

	lcd_mode_t  mode_q;
	logic [7:0] line_q;
	logic [8:0] wait_q;
	logic [8:0] wait_nxt;
	logic [7:0] line_inc;

	assign line_inc = line_q + 8'd1;

	always_comb begin
		mode_nxt = mode_q;
		line_nxt = line_q;
		wait_nxt = wait_q;
		evt      = '0;
		if (wait_q != 9'd0) begin
			wait_nxt = wait_q - 9'd1;
		end else begin
			unique case (mode_q)
				MODE_OAM: begin
					evt.stat = 1'b1;
					wait_nxt = DOTS_OAM;
					mode_nxt = MODE_XFER;
				end
				MODE_XFER: begin
					evt.stat = 1'b1;
					wait_nxt = DOTS_XFER;
					mode_nxt = MODE_HBLANK;
				end
				MODE_HBLANK: begin
					evt.stat   = 1'b1;
					evt.render = 1'b1;
					wait_nxt   = DOTS_HBLANK;
					if (line_q == LAST_VISIBLE_LINE) begin
						evt.vblank = 1'b1;
						mode_nxt   = MODE_VBLANK;
					end else begin
						line_nxt = line_inc;
						mode_nxt = MODE_OAM;
					end
				end
				default: begin
					wait_nxt = DOTS_LINE;
					line_nxt = line_inc;
					if (line_inc > LAST_LINE) begin
						line_nxt = 8'd0;
						mode_nxt = MODE_OAM;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HBLANK;
			line_q <= 8'd0;
			wait_q <= 9'd0;
		end else if (advance) begin
			mode_q <= mode_nxt;
			line_q <= line_nxt;
			wait_q <= wait_nxt;
		end
	end

endmodule

>>> hw/rtl/handheld_timer_lcd_irq_tick_top.sv
// ----------------------------------------------------------------------------
// handheld_timer_lcd_irq_tick_top
// Divider, timer counter, LCD mode sequencer and interrupt dispatcher,
// advanced by one machine tick per input word.
// ----------------------------------------------------------------------------
// Result: each accepted tick word's result word is registered and shown in the next cycle.
// Throughput: one tick word per cycle; the single output register is the
//   only stage, and it takes a new word whenever it is empty or being drained.
// Reset: arst_n clears all counters, flags, the mode (hblank), the
//   configuration registers and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module handheld_timer_lcd_irq_tick_top #(
	parameter int unsigned TICKS_PER_FRAME = htlit_pkg::TICKS_PER_FRAME_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// tick words in
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               master_enable,
	input  logic [4:0]                         external_requests,
	// result words out
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               irq_taken,
	output logic [6:0]                         irq_vector,
	output logic                               clear_master_enable,
	output logic                               wake_from_halt,
	output logic [4:0]                         pending_flags,
	output logic [1:0]                         lcd_mode,
	output logic [7:0]                         line_number,
	output logic                               render_line,
	output logic [7:0]                         divider_value,
	output logic [7:0]                         timer_value,
	// configuration writes
	input  logic                               cfg_we,
	input  logic [htlit_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [htlit_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import htlit_pkg::*;

	localparam int unsigned FT_W = $clog2(TICKS_PER_FRAME);

	// configuration registers
	logic [IRQ_N-1:0] irq_mask_q;
	logic             timer_run_q;
	logic [1:0]       timer_rate_q;
	logic [7:0]       timer_reload_q;

	// tick state
	logic [FT_W-1:0]  frame_tick_q;
	logic [7:0]       prescale_q;
	logic [7:0]       divider_q;
	logic [7:0]       timer_q;
	logic [IRQ_N-1:0] pending_q;

	// per-tick logic
	logic             accept;
	logic [FT_W:0]    frame_inc;
	logic [FT_W-1:0]  frame_nxt;
	logic [7:0]       divider_nxt;
	logic             timer_phase;
	logic             timer_step;
	logic             timer_ovf;
	logic [7:0]       timer_nxt;
	logic [IRQ_N-1:0] pending_merged;
	logic [IRQ_N-1:0] irq_ready;
	logic [IRQ_N-1:0] irq_clear;
	logic [2:0]       irq_src;
	logic             dispatch;
	logic [6:0]       vector_nxt;
	logic [IRQ_N-1:0] pending_nxt;
	lcd_mode_t        mode_nxt;
	logic [7:0]       line_nxt;
	lcd_evt_t         lcd_evt;

	// output register
	logic             out_valid_q;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// configuration decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_mask_q     <= '0;
			timer_run_q    <= 1'b0;
			timer_rate_q   <= RATE_1024;
			timer_reload_q <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IRQ_ENABLE:   irq_mask_q     <= cfg_data[IRQ_N-1:0];
				CFG_TIMER_RUN:    timer_run_q    <= cfg_data[0];
				CFG_TIMER_RATE:   timer_rate_q   <= cfg_data[1:0];
				CFG_TIMER_RELOAD: timer_reload_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// frame tick wraps at the frame length
	assign frame_inc = {1'b0, frame_tick_q} + {{FT_W{1'b0}}, 1'b1};
	assign frame_nxt = (frame_inc >= (FT_W+1)'(TICKS_PER_FRAME)) ? '0 : frame_inc[FT_W-1:0];

	// divider advances once every 256 ticks
	assign divider_nxt = (prescale_q == 8'hFF) ? divider_q + 8'd1 : divider_q;

	// timer steps where the frame tick is a multiple of the period
	always_comb begin
		case (timer_rate_q)
			RATE_16:  timer_phase = (frame_tick_q[3:0] == '0);
			RATE_64:  timer_phase = (frame_tick_q[5:0] == '0);
			RATE_256: timer_phase = (frame_tick_q[7:0] == '0);
			default:  timer_phase = (frame_tick_q[9:0] == '0);
		endcase
	end

	assign timer_step = timer_run_q && timer_phase;
	assign timer_ovf  = timer_step && (timer_q == 8'hFF);
	assign timer_nxt  = !timer_step ? timer_q :
	                    timer_ovf   ? timer_reload_q : timer_q + 8'd1;

	// merge timer overflow and outside requests before dispatch
	always_comb begin
		pending_merged = pending_q | external_requests;
		pending_merged[IRQ_TIMER] = pending_merged[IRQ_TIMER] | timer_ovf;
	end

	assign irq_ready = pending_merged & irq_mask_q;

	// lowest enabled pending source wins
	always_comb begin
		irq_src = 3'd0;
		for (int i = IRQ_N - 1; i >= 0; i--) begin
			if (irq_ready[i]) begin
				irq_src = 3'(i);
			end
		end
	end

	assign dispatch   = master_enable && (irq_ready != '0);
	assign irq_clear  = dispatch ? (IRQ_N)'(1) << irq_src : '0;
	assign vector_nxt = dispatch ? IRQ_VEC_BASE + {1'b0, irq_src, 3'b000} : 7'd0;

	// sequencer flags land after the dispatch decision
	always_comb begin
		pending_nxt = pending_merged & ~irq_clear;
		pending_nxt[IRQ_STAT]   = pending_nxt[IRQ_STAT] | lcd_evt.stat;
		pending_nxt[IRQ_VBLANK] = pending_nxt[IRQ_VBLANK] | lcd_evt.vblank;
	end

	htlit_lcd_seq u_lcd_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (accept),
		.mode_nxt (mode_nxt),
		.line_nxt (line_nxt),
		.evt      (lcd_evt)
	);

	// tick state advances on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_tick_q <= '0;
			prescale_q   <= 8'd0;
			divider_q    <= 8'd0;
			timer_q      <= 8'd0;
			pending_q    <= '0;
		end else if (accept) begin
			frame_tick_q <= frame_nxt;
			prescale_q   <= prescale_q + 8'd1;
			divider_q    <= divider_nxt;
			timer_q      <= timer_nxt;
			pending_q    <= pending_nxt;
		end
	end

	// result word: hold while stalled, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			irq_taken           <= dispatch;
			irq_vector          <= vector_nxt;
			clear_master_enable <= dispatch;
			wake_from_halt      <= (irq_ready != '0);
			pending_flags       <= pending_nxt;
			lcd_mode            <= mode_nxt;
			line_number         <= line_nxt;
			render_line         <= lcd_evt.render;
			divider_value       <= divider_nxt;
			timer_value         <= timer_nxt;
		end
	end

endmodule

>>> dv/tb_handheld_timer_lcd_irq_tick_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_handheld_timer_lcd_irq_tick_top
// Self-checking bench for the divider, timer, LCD mode and interrupt tick unit.
// Every tick word is mirrored into a tick-by-tick prediction of the unit, and
// each result word is matched field by field, in order, against it. A short
// directed opening hits dispatch priority and masking. Randomized phases with
// random gaps and stalls follow. A short near-full-rate sweep, with a fresh
// setting per segment, closes the run.
// ----------------------------------------------------------------------------
import htlit_pkg::*;

typedef struct packed {
	logic       irq_taken;
	logic [6:0] irq_vector;
	logic       clear_me;
	logic       wake;
	logic [4:0] pending;
	lcd_mode_t  mode;
	logic [7:0] line;
	logic       render;
	logic [7:0] divider;
	logic [7:0] timer;
} tick_word_t;

class tick_ledger;
	// register copies
	logic [4:0]  en_mask;
	logic        run;
	logic [1:0]  rate;
	logic [7:0]  reload;
	// unit state
	int unsigned frame_len;
	int unsigned frame_pos;
	logic [7:0]  div_pre;
	logic [7:0]  div_cnt;
	logic [7:0]  tmr_cnt;
	logic [4:0]  flags;
	lcd_mode_t   mode;
	logic [7:0]  line;
	logic [8:0]  dots;
	tick_word_t  due_words[$];
	// bookkeeping
	int unsigned errors, words_checked, ticks;
	int unsigned dispatches, overflows, vblank_entries, line_wraps, frame_wraps;

	function new(int unsigned frame_ticks);
		frame_len = frame_ticks;
		en_mask = '0;
		run = 1'b0;
		rate = RATE_1024;
		reload = '0;
		frame_pos = 0;
		div_pre = '0;
		div_cnt = '0;
		tmr_cnt = '0;
		flags = '0;
		mode = MODE_HBLANK;
		line = '0;
		dots = '0;
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_IRQ_ENABLE:   en_mask = data[4:0];
			CFG_TIMER_RUN:    run = data[0];
			CFG_TIMER_RATE:   rate = data[1:0];
			CFG_TIMER_RELOAD: reload = data;
			default: ;
		endcase
	endfunction

	function int unsigned timer_period();
		case (rate)
			RATE_16:  return 16;
			RATE_64:  return 64;
			RATE_256: return 256;
			default:  return 1024;
		endcase
	endfunction

	// Advance one tick and queue the word it must produce.
	function void push_tick(logic me, logic [4:0] ext);
		tick_word_t  w;
		logic [4:0]  ready;
		int unsigned src;
		w = '0;
		ticks++;
		if (div_pre == 8'd255) begin
			div_cnt++;
			div_pre = '0;
		end else begin
			div_pre++;
		end
		if (run && (frame_pos % timer_period()) == 0) begin
			if (tmr_cnt == 8'd255) begin
				tmr_cnt = reload;
				flags[IRQ_TIMER] = 1'b1;
				overflows++;
			end else begin
				tmr_cnt++;
			end
		end
		flags |= ext;
		ready = flags & en_mask;
		if (ready != '0) begin
			w.wake = 1'b1;
			if (me) begin
				src = 0;
				for (int b = IRQ_N - 1; b >= 0; b--) begin
					if (ready[b])
						src = b;
				end
				w.irq_taken = 1'b1;
				w.irq_vector = IRQ_VEC_BASE + 7'(src * 8);
				flags[src] = 1'b0;
				dispatches++;
			end
		end
		if (dots != '0) begin
			dots--;
		end else begin
			case (mode)
				MODE_OAM: begin
					flags[IRQ_STAT] = 1'b1;
					dots = DOTS_OAM;
					mode = MODE_XFER;
				end
				MODE_XFER: begin
					flags[IRQ_STAT] = 1'b1;
					dots = DOTS_XFER;
					mode = MODE_HBLANK;
				end
				MODE_HBLANK: begin
					flags[IRQ_STAT] = 1'b1;
					w.render = 1'b1;
					dots = DOTS_HBLANK;
					if (line == LAST_VISIBLE_LINE) begin
						flags[IRQ_VBLANK] = 1'b1;
						mode = MODE_VBLANK;
						vblank_entries++;
					end else begin
						line++;
						mode = MODE_OAM;
					end
				end
				default: begin
					dots = DOTS_LINE;
					line++;
					if (line > LAST_LINE) begin
						line = '0;
						mode = MODE_OAM;
						line_wraps++;
					end
				end
			endcase
		end
		if (frame_pos + 1 >= frame_len) begin
			frame_pos = 0;
			frame_wraps++;
		end else begin
			frame_pos++;
		end
		w.clear_me = w.irq_taken;
		w.pending = flags;
		w.mode = mode;
		w.line = line;
		w.divider = div_cnt;
		w.timer = tmr_cnt;
		due_words.push_back(w);
	endfunction

	function void flag(string msg);
		errors++;
		if (errors <= 100)
			$display("%0t: %s", $time, msg);
		if (errors == 100)
			$display("%0t: mismatch limit reached, further ones are counted only", $time);
	endfunction

	function void match_field(string field, int unsigned want, int unsigned seen);
		if (want != seen)
			flag($sformatf("word %0d field %s: expected %0d, actual %0d",
				words_checked, field, want, seen));
	endfunction

	function void check_word(tick_word_t seen);
		tick_word_t want;
		if (due_words.size() == 0) begin
			flag("result word with no tick outstanding");
			return;
		end
		want = due_words.pop_front();
		match_field("irq_taken", want.irq_taken, seen.irq_taken);
		match_field("irq_vector", want.irq_vector, seen.irq_vector);
		match_field("clear_master_enable", want.clear_me, seen.clear_me);
		match_field("wake_from_halt", want.wake, seen.wake);
		match_field("pending_flags", want.pending, seen.pending);
		match_field("lcd_mode", want.mode, seen.mode);
		match_field("line_number", want.line, seen.line);
		match_field("render_line", want.render, seen.render);
		match_field("divider_value", want.divider, seen.divider);
		match_field("timer_value", want.timer, seen.timer);
		words_checked++;
	endfunction
endclass

module tb_handheld_timer_lcd_irq_tick_top;

	localparam int unsigned FRAME_TICKS = TICKS_PER_FRAME_DEF;
	localparam int unsigned TIMEOUT_CYCLES = 2000;
	localparam int unsigned PHASES = 8;
	localparam int unsigned PHASE_TICKS = 105;
	localparam int unsigned SWEEP_SEGS = 2;
	localparam int unsigned SEG_TICKS = 95;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       master_enable;
	logic [4:0] external_requests;
	logic       out_valid;
	logic       out_ready;
	logic       irq_taken;
	logic [6:0] irq_vector;
	logic       clear_master_enable;
	logic       wake_from_halt;
	logic [4:0] pending_flags;
	logic [1:0] lcd_mode;
	logic [7:0] line_number;
	logic       render_line;
	logic [7:0] divider_value;
	logic [7:0] timer_value;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tick_ledger  ledger = new(FRAME_TICKS);
	tick_word_t  seen_word;
	logic [1:0]  rate_cycle[4] = '{RATE_1024, RATE_16, RATE_64, RATE_256};

	// pause shaping, one pair per side: ceiling of a draw and odds against it
	int unsigned gap_ceiling = 13;
	int unsigned gap_odds = 0;
	int unsigned stall_ceiling = 13;
	int unsigned stall_odds = 0;
	int unsigned quiet_cycles = 0;
	int unsigned settings_used = 0;

	handheld_timer_lcd_irq_tick_top #(
		.TICKS_PER_FRAME(FRAME_TICKS)
	) dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.master_enable       (master_enable),
		.external_requests   (external_requests),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.irq_taken           (irq_taken),
		.irq_vector          (irq_vector),
		.clear_master_enable (clear_master_enable),
		.wake_from_halt      (wake_from_halt),
		.pending_flags       (pending_flags),
		.lcd_mode            (lcd_mode),
		.line_number         (line_number),
		.render_line         (render_line),
		.divider_value       (divider_value),
		.timer_value         (timer_value),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Draw a pause length; odds of N mean a pause is drawn about once in N+1 words.
	function automatic int unsigned draw_pause(int unsigned ceiling, int unsigned odds);
		if (ceiling == 0 || $urandom_range(0, odds) != 0)
			return 0;
		return $urandom_range(0, ceiling);
	endfunction

	// Mostly quiet request lines, with single sources and random bursts mixed in.
	function automatic logic [4:0] draw_requests(int unsigned quiet_odds);
		if ($urandom_range(0, quiet_odds) != 0)
			return '0;
		if ($urandom_range(0, 2) != 0)
			return 5'(1 << $urandom_range(0, IRQ_N - 1));
		return 5'($urandom_range(0, 31));
	endfunction

	// Present one tick word after a random gap and hold it until it is taken.
	task automatic send_tick(input logic me, input logic [4:0] ext);
		int unsigned gap;
		gap = draw_pause(gap_ceiling, gap_odds);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		master_enable <= me;
		external_requests <= ext;
		do @(posedge clk); while (!in_ready);
		ledger.push_tick(me, ext);
	endtask

	task automatic park_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Wait until every queued word has come back, then let the pipe settle.
	task automatic drain();
		while (ledger.due_words.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		ledger.set_reg(idx, data);
	endtask

	// Load all four registers; only call with the unit idle.
	task automatic load_config(input logic [4:0] mask, input logic run, input logic [1:0] rate,
			input logic [7:0] reload);
		write_reg(CFG_IRQ_ENABLE, CFG_DATA_W'(mask));
		write_reg(CFG_TIMER_RUN, CFG_DATA_W'(run));
		write_reg(CFG_TIMER_RATE, CFG_DATA_W'(rate));
		write_reg(CFG_TIMER_RELOAD, reload);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic run_ticks(input int unsigned count, input int unsigned quiet_odds);
		for (int unsigned i = 0; i < count; i++)
			send_tick(1'($urandom_range(0, 1)), draw_requests(quiet_odds));
	endtask

	// Drain side: drop ready for a drawn number of cycles per word, then wait for one.
	initial begin
		int unsigned hold;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = draw_pause(stall_ceiling, stall_odds);
			@(negedge clk);
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Check every accepted result word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_word.irq_taken = irq_taken;
			seen_word.irq_vector = irq_vector;
			seen_word.clear_me = clear_master_enable;
			seen_word.wake = wake_from_halt;
			seen_word.pending = pending_flags;
			seen_word.mode = lcd_mode_t'(lcd_mode);
			seen_word.line = line_number;
			seen_word.render = render_line;
			seen_word.divider = divider_value;
			seen_word.timer = timer_value;
			ledger.check_word(seen_word);
		end
	end

	// Watchdog: give up after a long stretch with no word moving on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= TIMEOUT_CYCLES) begin
			$display("%0t: no word moved for %0d cycles", $time, TIMEOUT_CYCLES);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		master_enable = 1'b0;
		external_requests = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_IRQ_ENABLE;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: all sources enabled, fast timer, reload at its top value.
		load_config(5'h1f, 1'b1, RATE_16, 8'hff);
		send_tick(1'b0, 5'h00);		// first hblank step raises stat, pulses render
		send_tick(1'b1, 5'h00);		// stat dispatched
		send_tick(1'b0, 5'h1f);		// master enable clear: wake only, flags stay
		repeat (5)
			send_tick(1'b1, 5'h00);	// drain pending in priority order
		for (int k = 0; k < IRQ_N; k++)
			send_tick(1'b1, 5'(1 << k));
		send_tick(1'b1, 5'h1f);
		park_input();
		drain();

		// Everything masked, timer held: no wake, flags pile up.
		load_config(5'h00, 1'b0, RATE_1024, 8'h00);
		send_tick(1'b1, 5'h1f);
		send_tick(1'b0, 5'h00);
		park_input();
		drain();

		// Only the top source enabled: it wins although lower bits are pending.
		load_config(5'h10, 1'b1, RATE_256, 8'h00);
		send_tick(1'b1, 5'h00);
		send_tick(1'b1, 5'h00);
		send_tick(1'b0, 5'h10);
		send_tick(1'b1, 5'h00);
		park_input();
		drain();

		// Random phases with full gaps and stalls, some run back to back.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: load_config(5'h00, 1'b0, RATE_1024, 8'h00);
				1: load_config(5'h1f, 1'b1, RATE_16, 8'hff);
				default: load_config(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
					rate_cycle[$urandom_range(0, 3)], 8'($urandom_range(0, 255)));
			endcase
			gap_ceiling = (p % 4 == 3) ? 0 : 13;
			stall_ceiling = (p % 4 == 2) ? 0 : 13;
			gap_odds = 0;
			stall_odds = 0;
			run_ticks(PHASE_TICKS, 2);
			park_input();
			drain();
		end

		// Sweep at near full rate; each segment takes a fresh setting.
		gap_ceiling = 13;
		stall_ceiling = 13;
		gap_odds = 40;
		stall_odds = 40;
		for (int s = 0; s < SWEEP_SEGS; s++) begin
			load_config(5'($urandom_range(0, 31)), 1'(s % 5 != 3), rate_cycle[s % 4],
				($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom_range(0, 255)));
			run_ticks(SEG_TICKS, 15);
			park_input();
			drain();
		end

		$display("checked %0d tick words over %0d settings: %0d dispatches, %0d timer overflows",
			ledger.words_checked, settings_used, ledger.dispatches, ledger.overflows);
		$display("lcd went through %0d vblank entries and %0d line wraps, %0d frame wraps",
			ledger.vblank_entries, ledger.line_wraps, ledger.frame_wraps);
		if (ledger.errors == 0 && ledger.due_words.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d words still outstanding", ledger.errors,
				ledger.due_words.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
